[rtl/lrle_pkg.sv]
// shared types, character codes, parse mode codes and defaults for the
// run-length pattern decoder; no dependencies
package lrle_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_COUNT_BITS = 16;
    localparam int FIELD_W        = 16;

    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_O      = 8'h6F;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [3:0] RADIX       = 4'd10;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_SKIP  = 2'd1;
    localparam logic [1:0] MODE_COUNT = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] run_x;
        logic [FIELD_W-1:0] run_y;
        logic [FIELD_W-1:0] run_length;
        logic               has_run;
        logic               pattern_done;
        logic               overflowed;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_tag(input logic [7:0] c);
        return (c == CHAR_B) || (c == CHAR_O) || (c == CHAR_DOLLAR) || (c == CHAR_BANG);
    endfunction

endpackage

[rtl/lrle_step.sv]
// per-byte parse update: next mode, count, coordinates, overflow flag and
// the result for one byte; depends on lrle_pkg
module lrle_step #(
    parameter int COORD_BITS = lrle_pkg::DEF_COORD_BITS,
    parameter int COUNT_BITS = lrle_pkg::DEF_COUNT_BITS
) (
    input  logic [7:0]            i_byte,
    input  logic                  i_fin,
    input  logic [1:0]            i_mode,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_ovf,
    output logic [1:0]            o_mode,
    output logic [COUNT_BITS-1:0] o_count,
    output logic [COORD_BITS-1:0] o_x,
    output logic [COORD_BITS-1:0] o_y,
    output logic                  o_ovf,
    output logic                  o_emit,
    output lrle_pkg::t_result     o_res
);

    localparam int FW    = lrle_pkg::FIELD_W;
    localparam int MUL_W = COUNT_BITS + 4;
    localparam int SUM_W = ((COORD_BITS > COUNT_BITS) ? COORD_BITS : COUNT_BITS) + 1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [3:0]            digit;
    logic [MUL_W-1:0]      acc_next;
    logic [COUNT_BITS-1:0] cnt_raw;
    logic [COUNT_BITS-1:0] cnt;
    logic [SUM_W-1:0]      x_sum;
    logic [SUM_W-1:0]      y_sum;
    logic [COORD_BITS-1:0] x_sat;
    logic [COORD_BITS-1:0] y_sat;
    logic                  x_hit;
    logic                  y_hit;
    logic                  tag_en;
    logic                  run;
    logic                  done;
    logic                  active;

    assign digit    = 4'(i_byte - lrle_pkg::CHAR_ZERO);
    assign acc_next = MUL_W'(i_count) * MUL_W'(lrle_pkg::RADIX) + MUL_W'(digit);

    // absent or zero count means one
    assign cnt_raw = (i_mode == lrle_pkg::MODE_COUNT) ? i_count : COUNT_BITS'(1);
    assign cnt     = (cnt_raw == '0) ? COUNT_BITS'(1) : cnt_raw;

    assign x_sum = SUM_W'(i_x) + SUM_W'(cnt);
    assign y_sum = SUM_W'(i_y) + SUM_W'(cnt);
    assign x_hit = x_sum > SUM_W'(COORD_MAX);
    assign y_hit = y_sum > SUM_W'(COORD_MAX);
    assign x_sat = x_hit ? COORD_MAX : COORD_BITS'(x_sum);
    assign y_sat = y_hit ? COORD_MAX : COORD_BITS'(y_sum);

    always_comb begin
        o_mode  = i_mode;
        o_count = i_count;
        o_x     = i_x;
        o_y     = i_y;
        o_ovf   = i_ovf;
        tag_en  = 1'b0;
        run     = 1'b0;
        done    = 1'b0;
        active  = 1'b1;
        o_res   = '0;

        case (i_mode)
            lrle_pkg::MODE_START: begin
                if (lrle_pkg::is_blank(i_byte)) begin
                    o_mode = lrle_pkg::MODE_START;
                end else if (lrle_pkg::is_digit(i_byte)) begin
                    o_count = COUNT_BITS'(digit);
                    o_mode  = lrle_pkg::MODE_COUNT;
                end else if (lrle_pkg::is_tag(i_byte)) begin
                    tag_en = 1'b1;
                end else begin
                    o_mode = lrle_pkg::MODE_SKIP;
                end
            end
            lrle_pkg::MODE_SKIP: begin
                if (i_byte == lrle_pkg::CHAR_NL) begin
                    o_mode = lrle_pkg::MODE_START;
                end
            end
            lrle_pkg::MODE_COUNT: begin
                if (lrle_pkg::is_digit(i_byte)) begin
                    if (acc_next > MUL_W'(COUNT_MAX)) begin
                        o_count = COUNT_MAX;
                        o_ovf   = 1'b1;
                    end else begin
                        o_count = COUNT_BITS'(acc_next);
                    end
                end else begin
                    tag_en  = 1'b1;
                    o_count = '0;
                    o_mode  = lrle_pkg::MODE_START;
                end
            end
            default: begin
                // pattern ended: everything waits for the final byte
                active = 1'b0;
                if (i_fin) begin
                    o_mode = lrle_pkg::MODE_START;
                end
            end
        endcase

        if (tag_en) begin
            case (i_byte)
                lrle_pkg::CHAR_B: begin
                    o_x   = x_sat;
                    o_ovf = o_ovf | x_hit;
                end
                lrle_pkg::CHAR_O: begin
                    run              = 1'b1;
                    o_res.run_x      = FW'(i_x);
                    o_res.run_y      = FW'(i_y);
                    o_res.run_length = FW'(cnt);
                    o_x              = x_sat;
                    o_ovf            = o_ovf | x_hit;
                end
                lrle_pkg::CHAR_DOLLAR: begin
                    o_y   = y_sat;
                    o_x   = '0;
                    o_ovf = o_ovf | y_hit;
                end
                lrle_pkg::CHAR_BANG: begin
                    done = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (active && i_fin) begin
            done = 1'b1;
        end

        o_res.has_run      = run;
        o_res.pattern_done = done;
        o_res.overflowed   = o_ovf;
        o_emit             = active && (run || done);

        // end of pattern returns all state to reset, or parks until the final byte
        if (done) begin
            o_mode  = i_fin ? lrle_pkg::MODE_START : lrle_pkg::MODE_DONE;
            o_count = '0;
            o_x     = '0;
            o_y     = '0;
            o_ovf   = 1'b0;
        end
        if (!active && i_fin) begin
            o_count = '0;
            o_x     = '0;
            o_y     = '0;
            o_ovf   = 1'b0;
        end
    end

endmodule

[rtl/lrle_out_reg.sv]
// result register between the parse stage and the result channel
// depends on lrle_pkg for the result type
module lrle_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_emit,
    input  lrle_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output lrle_pkg::t_result o_res
);

    logic              r_valid;
    lrle_pkg::t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_emit) begin
            r_res <= i_res;
        end
    end

endmodule

[rtl/life_rle_run_decoder.sv]
// top level of the run-length pattern decoder: input register, parse state
// registers, lrle_step and lrle_out_reg; depends on lrle_pkg
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_stall    i_text_byte, i_final_byte
//  result   out        o_out_valid / i_out_stall  o_run_x, o_run_y, o_run_length,
//                                                 o_has_run, o_pattern_done, o_overflowed
//
// one byte per cycle while the result channel is not stalled: a byte is held in the
// input register, is parsed by one level of logic and its result, if any, lands in
// the result register
// reset is synchronous, active low, and clears the parse state at once
// a stalled result holds the parse stage; one more byte is still taken
// into the input register while the result waits
module life_rle_run_decoder #(
    parameter int COORD_BITS = lrle_pkg::DEF_COORD_BITS,
    parameter int COUNT_BITS = lrle_pkg::DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_run_x,
    output logic [15:0] o_run_y,
    output logic [15:0] o_run_length,
    output logic        o_has_run,
    output logic        o_pattern_done,
    output logic        o_overflowed
);

    logic                  r_in_valid;
    logic [7:0]            r_byte;
    logic                  r_fin;
    logic [1:0]            r_mode;
    logic [COUNT_BITS-1:0] r_count;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    logic                  r_ovf;

    logic [1:0]            n_mode;
    logic [COUNT_BITS-1:0] n_count;
    logic [COORD_BITS-1:0] n_x;
    logic [COORD_BITS-1:0] n_y;
    logic                  n_ovf;

    logic              step_emit;
    lrle_pkg::t_result step_res;
    lrle_pkg::t_result out_res;
    logic              out_free;
    logic              advance;
    logic              in_take;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_text_byte;
            r_fin  <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lrle_pkg::MODE_START;
            r_count <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_ovf   <= 1'b0;
        end else if (advance) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_x     <= n_x;
            r_y     <= n_y;
            r_ovf   <= n_ovf;
        end
    end

    lrle_step #(
        .COORD_BITS(COORD_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_byte (r_byte),
        .i_fin  (r_fin),
        .i_mode (r_mode),
        .i_count(r_count),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_ovf  (r_ovf),
        .o_mode (n_mode),
        .o_count(n_count),
        .o_x    (n_x),
        .o_y    (n_y),
        .o_ovf  (n_ovf),
        .o_emit (step_emit),
        .o_res  (step_res)
    );

    lrle_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (advance),
        .i_emit (step_emit),
        .i_res  (step_res),
        .i_stall(i_out_stall),
        .o_free (out_free),
        .o_valid(o_out_valid),
        .o_res  (out_res)
    );

    assign o_run_x        = out_res.run_x;
    assign o_run_y        = out_res.run_y;
    assign o_run_length   = out_res.run_length;
    assign o_has_run      = out_res.has_run;
    assign o_pattern_done = out_res.pattern_done;
    assign o_overflowed   = out_res.overflowed;

`ifndef ASSERT_OFF
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_run |-> o_pattern_done)
        else $error("result with neither run nor pattern end");

    a_no_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_run |-> (o_run_x == '0) && (o_run_y == '0)
            && (o_run_length == '0))
        else $error("run fields not zero on a result without run");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_run |-> o_run_length != '0)
        else $error("live run of length zero");

    a_done_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == lrle_pkg::MODE_DONE |-> (r_x == '0) && (r_y == '0)
            && (r_count == '0) && !r_ovf)
        else $error("state not cleared after pattern end");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != lrle_pkg::MODE_COUNT |-> r_count == '0)
        else $error("count held outside a count element");
`endif

endmodule
